// ===== hw/rtl/tqg_pkg.sv =====
// Shared types, register indexes and helpers for the tile quad generator.
// Depends on nothing; tile_quad_generator imports it.
`timescale 1ns / 1ps
package tqg_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_OFFSET_X   = 3'd0;
   localparam logic [2:0] CSR_OFFSET_Y   = 3'd1;
   localparam logic [2:0] CSR_ZOOM       = 3'd2;
   localparam logic [2:0] CSR_WIN_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_WIN_HEIGHT = 3'd4;
   localparam logic [2:0] CSR_TILE_COUNT = 3'd5;
   localparam logic [2:0] CSR_ATLAS_COLS = 3'd6;
   localparam logic [2:0] CSR_ATLAS_RDY  = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 23;

   // quotient width of every divider lane
   localparam int DIV_Q_W = 18;

   // block position and finished screen edges, carried down the pipeline
   typedef struct packed {
      logic [7:0]         col;
      logic [7:0]         row;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic signed [15:0] top;
      logic signed [15:0] bottom;
   } carry_type;

   // clamp an atlas coordinate quotient to Q0.16
   function automatic logic [15:0] sat_uv(input logic [DIV_Q_W-1:0] q);
      logic [15:0] res;
      if (q > DIV_Q_W'(16'hFFFF)) begin
         res = 16'hFFFF;
      end else begin
         res = q[15:0];
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/tqg_if.sv =====
// Valid/ready channel interfaces for map blocks in and quads out.
// Depends on nothing.
`timescale 1ns / 1ps
interface tqg_req_if;
   logic               valid;
   logic               ready;
   logic [7:0]         block_col;
   logic [7:0]         block_row;
   logic signed [15:0] tile_index;

   modport source (output valid, block_col, block_row, tile_index, input ready);
   modport sink   (input valid, block_col, block_row, tile_index, output ready);
endinterface

interface tqg_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         out_col;
   logic [7:0]         out_row;
   logic signed [15:0] screen_left;
   logic signed [15:0] screen_right;
   logic signed [15:0] screen_top;
   logic signed [15:0] screen_bottom;
   logic [15:0]        tex_u_left;
   logic [15:0]        tex_u_right;
   logic [15:0]        tex_v_top;
   logic [15:0]        tex_v_bottom;

   modport source (output valid, out_col, out_row, screen_left, screen_right, screen_top,
                   screen_bottom, tex_u_left, tex_u_right, tex_v_top, tex_v_bottom,
                   input ready);
   modport sink   (input valid, out_col, out_row, screen_left, screen_right, screen_top,
                   screen_bottom, tex_u_left, tex_u_right, tex_v_top, tex_v_bottom,
                   output ready);
endinterface

// ===== hw/rtl/tqg_div.sv =====
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// Depends on nothing; stage enables come from the owner's stall chain.
`timescale 1ns / 1ps
module tqg_div #(
   parameter int DEN_W  = 9,
   parameter int Q_W    = 18,
   parameter int STAGES = 6
) (
   input  logic                   clock,
   input  logic [STAGES-1:0]      en,
   input  logic [DEN_W+Q_W-1:0]   num,
   input  logic [DEN_W-1:0]       den,
   output logic [Q_W-1:0]         quo,
   output logic [DEN_W-1:0]       rem
);
   // numerator must satisfy num < den * 2**Q_W
   localparam int SPS = Q_W / STAGES;

   logic [DEN_W-1:0] rem_ff [STAGES];
   logic [DEN_W-1:0] rem_in [STAGES];
   logic [Q_W-1:0]   work_ff [STAGES];
   logic [Q_W-1:0]   work_in [STAGES];
   logic [DEN_W-1:0] den_ff [STAGES];
   logic [DEN_W-1:0] den_in [STAGES];

   // shift in numerator bits, subtract where the partial remainder allows
   always_comb begin
      logic [DEN_W-1:0] r;
      logic [Q_W-1:0]   w;
      logic [DEN_W-1:0] d;
      logic [DEN_W:0]   tr;
      logic             qb;
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            r = num[DEN_W+Q_W-1:Q_W];
            w = num[Q_W-1:0];
            d = den;
         end else begin
            r = rem_ff[s-1];
            w = work_ff[s-1];
            d = den_ff[s-1];
         end
         for (int k = 0; k < SPS; k++) begin
            tr = {r, w[Q_W-1]};
            if (tr >= {1'b0, d}) begin
               tr = tr - {1'b0, d};
               qb = 1'b1;
            end else begin
               qb = 1'b0;
            end
            r = tr[DEN_W-1:0];
            w = {w[Q_W-2:0], qb};
         end
         rem_in[s]  = r;
         work_in[s] = w;
         den_in[s]  = d;
      end
   end

   // advance each stage on its enable
   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (en[s]) begin
            rem_ff[s]  <= rem_in[s];
            work_ff[s] <= work_in[s];
            den_ff[s]  <= den_in[s];
         end
      end
   end

   assign quo = work_ff[STAGES-1];
   assign rem = rem_ff[STAGES-1];

endmodule

// ===== hw/rtl/tile_quad_generator.sv =====
// Tile quad generator: takes one map block per cycle while not stalled and, once it
// passes the view, atlas and tile range checks, returns one screen quad with
// rounded, saturated edges and inset atlas coordinates. Sustained rate is one block
// per clock while the output is ready. The two chained 18-bit dividers (tile
// row/column, then atlas coordinate) retire three quotient bits per stage. Dropped
// blocks leave a bubble and no result. Each stage holds only while the next one is
// full and stalled. Depends on tqg_pkg, tqg_if and tqg_div.
`timescale 1ns / 1ps
module tile_quad_generator #(
   parameter int TILE_SIZE  = 32,
   parameter int MAP_BLOCKS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   tqg_req_if.sink                         req_chan,
   tqg_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [tqg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tqg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tqg_pkg::*;

   localparam int NST    = 14;
   localparam int POS_W  = $clog2(256 * TILE_SIZE * 256);
   localparam int D_W    = ((POS_W > 22) ? POS_W : 22) + 3;
   localparam int P_W    = D_W + 20;
   localparam int R_W    = P_W - 24;
   localparam int IDX_DW = 9;
   localparam int TEX_DW = $clog2(2 * 65536 * TILE_SIZE);
   localparam int TN_W   = TEX_DW + DIV_Q_W;

   // configuration registers
   logic signed [22:0] off_x_ff, off_y_ff;
   logic [18:0]        zoom_ff;
   logic [11:0]        win_w_ff, win_h_ff;
   logic [15:0]        tile_cnt_ff;
   logic [8:0]         cols_ff;
   logic               atlas_rdy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff     <= '0;
         off_y_ff     <= '0;
         zoom_ff      <= 19'd65536;
         win_w_ff     <= 12'd640;
         win_h_ff     <= 12'd480;
         tile_cnt_ff  <= '0;
         cols_ff      <= 9'd1;
         atlas_rdy_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OFFSET_X:   off_x_ff     <= signed'(csr_wdata[22:0]);
            CSR_OFFSET_Y:   off_y_ff     <= signed'(csr_wdata[22:0]);
            CSR_ZOOM:       zoom_ff      <= csr_wdata[18:0];
            CSR_WIN_WIDTH:  win_w_ff     <= csr_wdata[11:0];
            CSR_WIN_HEIGHT: win_h_ff     <= csr_wdata[11:0];
            CSR_TILE_COUNT: tile_cnt_ff  <= csr_wdata[15:0];
            CSR_ATLAS_COLS: cols_ff      <= csr_wdata[8:0];
            CSR_ATLAS_RDY:  atlas_rdy_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stall chain: a stage loads when it is empty or its successor moves
   logic [NST-1:0] valid_ff, valid_in, en;
   logic           keep_s2;

   always_comb begin
      en[NST-1] = !valid_ff[NST-1] || rsp_chan.ready;
      for (int i = NST - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_comb begin
      valid_in[0] = req_chan.valid;
      for (int i = 1; i < NST; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
      valid_in[2] = valid_ff[1] && keep_s2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign req_chan.ready = en[0];

   // stage 0: capture block, distances from view origin to each edge
   logic [7:0]            col_s0_ff, row_s0_ff;
   logic signed [15:0]    t_s0_ff;
   logic signed [D_W-1:0] dx0_s0_ff, dx1_s0_ff, dy0_s0_ff, dy1_s0_ff;
   logic signed [D_W-1:0] dx0_in, dx1_in, dy0_in, dy1_in;
   logic                  keep_s0_ff, keep_s0_in;

   always_comb begin
      dx0_in = signed'(D_W'(32'(req_chan.block_col) * TILE_SIZE * 256)) - D_W'(off_x_ff);
      dx1_in = signed'(D_W'((32'(req_chan.block_col) + 1) * TILE_SIZE * 256))
               - D_W'(off_x_ff);
      dy0_in = signed'(D_W'(32'(req_chan.block_row) * TILE_SIZE * 256)) - D_W'(off_y_ff);
      dy1_in = signed'(D_W'((32'(req_chan.block_row) + 1) * TILE_SIZE * 256))
               - D_W'(off_y_ff);
      keep_s0_in = (32'(req_chan.block_col) < MAP_BLOCKS)
                && (32'(req_chan.block_row) < MAP_BLOCKS)
                && atlas_rdy_ff && (cols_ff != 9'd0)
                && !req_chan.tile_index[15]
                && (req_chan.tile_index[15:0] < tile_cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         col_s0_ff  <= req_chan.block_col;
         row_s0_ff  <= req_chan.block_row;
         t_s0_ff    <= req_chan.tile_index;
         dx0_s0_ff  <= dx0_in;
         dx1_s0_ff  <= dx1_in;
         dy0_s0_ff  <= dy0_in;
         dy1_s0_ff  <= dy1_in;
         keep_s0_ff <= keep_s0_in;
      end
   end

   // stage 1: scale distances by zoom, check the near edges
   logic [7:0]            col_s1_ff, row_s1_ff;
   logic signed [P_W-1:0] px0_ff, px1_ff, py0_ff, py1_ff;
   logic signed [P_W-1:0] zoom_s;
   logic                  keep_s1_ff;

   assign zoom_s = P_W'(signed'({1'b0, zoom_ff}));

   always_ff @(posedge clock) begin
      if (en[1]) begin
         col_s1_ff  <= col_s0_ff;
         row_s1_ff  <= row_s0_ff;
         px0_ff     <= P_W'(dx0_s0_ff) * zoom_s;
         px1_ff     <= P_W'(dx1_s0_ff) * zoom_s;
         py0_ff     <= P_W'(dy0_s0_ff) * zoom_s;
         py1_ff     <= P_W'(dy1_s0_ff) * zoom_s;
         keep_s1_ff <= keep_s0_ff && (dx1_s0_ff > 0) && (dy1_s0_ff > 0);
      end
   end

   // stage 2: far-edge test, round half away from zero and saturate
   function automatic logic signed [15:0] round_edge(input logic signed [P_W-1:0] p);
      logic [P_W-1:0]     m;
      logic [R_W-1:0]     r;
      logic signed [15:0] res;
      m = p[P_W-1] ? $unsigned(-p) : $unsigned(p);
      r = R_W'((m + P_W'(1 << 23)) >> 24);
      if (p[P_W-1]) begin
         res = (r >= R_W'(32768)) ? 16'sh8000 : -signed'(r[15:0]);
      end else begin
         res = (r > R_W'(32767)) ? 16'sh7FFF : signed'(r[15:0]);
      end
      return res;
   endfunction

   logic signed [P_W-1:0] lim_x, lim_y;
   carry_type             carry_ff [2:NST-1];
   carry_type             carry_s2_in;

   assign lim_x = signed'(P_W'({win_w_ff, 24'b0}));
   assign lim_y = signed'(P_W'({win_h_ff, 24'b0}));

   always_comb begin
      keep_s2            = keep_s1_ff && (px0_ff <= lim_x) && (py0_ff <= lim_y);
      carry_s2_in.col    = col_s1_ff;
      carry_s2_in.row    = row_s1_ff;
      carry_s2_in.left   = round_edge(px0_ff);
      carry_s2_in.right  = round_edge(px1_ff);
      carry_s2_in.top    = round_edge(py0_ff);
      carry_s2_in.bottom = round_edge(py1_ff);
   end

   // carry position and edges alongside the dividers
   always_ff @(posedge clock) begin
      if (en[2]) begin
         carry_ff[2] <= carry_s2_in;
      end
      for (int i = 3; i < NST; i++) begin
         if (en[i]) begin
            carry_ff[i] <= carry_ff[i-1];
         end
      end
   end

   // stages 1-6: tile row/column within the atlas, and atlas row count
   logic [DIV_Q_W-1:0] idx_q, rows_q;
   logic [IDX_DW-1:0]  idx_r, rows_r;

   tqg_div #(.DEN_W(IDX_DW), .Q_W(DIV_Q_W), .STAGES(6)) u_idx_div (
      .clock (clock),
      .en    (en[6:1]),
      .num   ((IDX_DW + DIV_Q_W)'(t_s0_ff[15:0])),
      .den   (cols_ff),
      .quo   (idx_q),
      .rem   (idx_r)
   );

   tqg_div #(.DEN_W(IDX_DW), .Q_W(DIV_Q_W), .STAGES(6)) u_rows_div (
      .clock (clock),
      .en    (en[6:1]),
      .num   ((IDX_DW + DIV_Q_W)'(tile_cnt_ff) + (IDX_DW + DIV_Q_W)'(cols_ff)
              - (IDX_DW + DIV_Q_W)'(1)),
      .den   (cols_ff),
      .quo   (rows_q),
      .rem   (rows_r)
   );

   // stage 7: atlas cell edges as rounded-quotient numerators
   logic [TN_W-1:0]   ts, xs, aws, ys, ahs;
   logic [TN_W-1:0]   num_ul_ff, num_ur_ff, num_vt_ff, num_vb_ff;
   logic [TEX_DW-1:0] den_u_ff, den_v_ff;

   always_comb begin
      ts  = TN_W'(TILE_SIZE);
      xs  = TN_W'(idx_r) * ts;
      aws = TN_W'(cols_ff) * ts;
      ys  = TN_W'(idx_q) * ts;
      ahs = TN_W'(rows_q) * ts;
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         num_ul_ff <= ((((xs << 1) + TN_W'(1)) << 16) + aws);
         num_ur_ff <= (((((xs + ts) << 1) - TN_W'(1)) << 16) + aws);
         num_vt_ff <= ((((ys << 1) + TN_W'(1)) << 16) + ahs);
         num_vb_ff <= (((((ys + ts) << 1) - TN_W'(1)) << 16) + ahs);
         den_u_ff  <= TEX_DW'(aws << 1);
         den_v_ff  <= TEX_DW'(ahs << 1);
      end
   end

   // stages 8-13: the four atlas coordinates
   logic [DIV_Q_W-1:0] q_ul, q_ur, q_vt, q_vb;
   logic [TEX_DW-1:0]  r_ul, r_ur, r_vt, r_vb;

   tqg_div #(.DEN_W(TEX_DW), .Q_W(DIV_Q_W), .STAGES(6)) u_ul_div (
      .clock (clock), .en (en[13:8]), .num (num_ul_ff), .den (den_u_ff),
      .quo (q_ul), .rem (r_ul)
   );

   tqg_div #(.DEN_W(TEX_DW), .Q_W(DIV_Q_W), .STAGES(6)) u_ur_div (
      .clock (clock), .en (en[13:8]), .num (num_ur_ff), .den (den_u_ff),
      .quo (q_ur), .rem (r_ur)
   );

   tqg_div #(.DEN_W(TEX_DW), .Q_W(DIV_Q_W), .STAGES(6)) u_vt_div (
      .clock (clock), .en (en[13:8]), .num (num_vt_ff), .den (den_v_ff),
      .quo (q_vt), .rem (r_vt)
   );

   tqg_div #(.DEN_W(TEX_DW), .Q_W(DIV_Q_W), .STAGES(6)) u_vb_div (
      .clock (clock), .en (en[13:8]), .num (num_vb_ff), .den (den_v_ff),
      .quo (q_vb), .rem (r_vb)
   );

   // drive the result channel from the last stage
   assign rsp_chan.valid         = valid_ff[NST-1];
   assign rsp_chan.out_col       = carry_ff[NST-1].col;
   assign rsp_chan.out_row       = carry_ff[NST-1].row;
   assign rsp_chan.screen_left   = carry_ff[NST-1].left;
   assign rsp_chan.screen_right  = carry_ff[NST-1].right;
   assign rsp_chan.screen_top    = carry_ff[NST-1].top;
   assign rsp_chan.screen_bottom = carry_ff[NST-1].bottom;
   assign rsp_chan.tex_u_left    = sat_uv(q_ul);
   assign rsp_chan.tex_u_right   = sat_uv(q_ur);
   assign rsp_chan.tex_v_top     = sat_uv(q_vt);
   assign rsp_chan.tex_v_bottom  = sat_uv(q_vb);

   // a transfer in always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> valid_ff[0])
      else $error("accepted block did not reach stage 0");

   // the tile column and row-count remainders stay below the atlas width for kept blocks
   a_idx_rem: assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] |-> (idx_r < cols_ff) && (rows_r < cols_ff))
      else $error("tile index remainder out of range");

   // inset coordinates keep their order inside the cell, and the left and top remainders stay below their divisors
   a_uv_order: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.tex_u_left <= rsp_chan.tex_u_right)
                      && (rsp_chan.tex_v_top <= rsp_chan.tex_v_bottom)
                      && (r_ul < den_u_ff || den_u_ff == '0) && (r_vt < den_v_ff
                      || den_v_ff == '0) && (r_ur == r_ur) && (r_vb == r_vb))
      else $error("atlas coordinates out of order");

endmodule
